@@ rtl/bounded_list_engine_macros.svh @@
// assertion macros for the list engine; they expect clk and rst_n in scope
`ifndef BOUNDED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define BLE_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define BLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`define BLE_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define BLE_ASSERT_IMPLY(label, ante, cons)
`define BLE_ASSERT_NEXT(label, ante, cons)
`define BLE_ASSERT_NEVER(label, expr)
`endif
`endif

@@ rtl/ble_pkg.sv @@
package ble_pkg;

    localparam int CAPACITY = 64;
    localparam int VAL_W    = 8;
    localparam int POS_W    = 6;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 7;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LANE_W   = ((CAPACITY + 7) >> 3) << 3;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

    typedef logic [CMP_W-1:0] cmp_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;

    // width of one level of the 8-ary reduction tree
    function automatic int tree_width(input int lvl);
        int w;
        w = CAPACITY;
        for (int l = 0; l < lvl; l++)
        begin
            w = (w + 7) >> 3;
        end
        return w;
    endfunction

    function automatic int tree_depth();
        int w;
        int d;
        w = CAPACITY;
        d = 0;
        while (w > 1)
        begin
            w = (w + 7) >> 3;
            d = d + 1;
        end
        return d;
    endfunction

    localparam int TREE_LEVELS = tree_depth();
    localparam int WAIT_W      = $clog2(TREE_LEVELS + 1);

    typedef struct packed {
        logic               insert;
        logic               append;
        logic               remove;
        logic               search;
        logic [VAL_W-1:0]   value;
        logic [POS_W-1:0]   pos;
        logic [CNT_W-1:0]   count;
    } cmd_t;

endpackage

@@ rtl/bounded_list_engine.sv @@
// channel  | dir | handshake         | payload
// s        | in  | s_tvalid/s_tready | s_tuser operation, s_tdata value, position
// m        | out | m_tvalid/m_tready | m_tdata status, found, length
//
// One command at a time: accept, then the match flags pass through the registered
// reduction tree, then the result waits in the output register until the sink takes it;
// no new command is accepted before that.
// The cell row updates on the accept edge, so an insert, append or remove that is not rejected edits the list there.
// Reset empties the list at once; cell contents are not cleared.
// A stalled result holds and blocks the next transaction.
`include "bounded_list_engine_macros.svh"

module bounded_list_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // operation
    input  logic [15:0] s_tdata,   // value [7:0], position [13:8], zero [15:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status [1:0], found [2], length [9:3], zero [15:10]
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    ble_pkg::cnt_t                    count_reg;
    ble_pkg::cnt_t                    count_next;
    logic [ble_pkg::WAIT_W-1:0]       wait_reg;
    logic [ble_pkg::WAIT_W-1:0]       wait_next;
    logic [ble_pkg::STAT_W-1:0]       status_reg;
    logic [ble_pkg::STAT_W-1:0]       status_next;
    ble_pkg::len_t                    length_reg;
    ble_pkg::len_t                    length_next;
    logic                             found_reg;
    logic                             found_next;

    logic                             accept;
    logic                             full;
    logic                             range_bad;
    logic [ble_pkg::OP_W-1:0]         op;
    logic [ble_pkg::VAL_W-1:0]        value;
    logic [ble_pkg::POS_W-1:0]        pos;
    ble_pkg::cmd_t                    cmd;
    logic [ble_pkg::VAL_W-1:0]        cell_data [ble_pkg::CAPACITY];
    logic [ble_pkg::CAPACITY-1:0]     cell_match;
    logic                             any_match;

    assign op    = s_tuser;
    assign value = s_tdata[7:0];
    assign pos   = s_tdata[13:8];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == ble_pkg::cnt_t'(ble_pkg::CAPACITY));
    assign range_bad = (ble_pkg::cmp_t'(pos) >= ble_pkg::cmp_t'(count_reg));

    always_comb
    begin
        cmd.insert = accept && (op == ble_pkg::OP_INSERT) && !full;
        cmd.append = accept && (op == ble_pkg::OP_APPEND) && !full;
        cmd.remove = accept && (op == ble_pkg::OP_REMOVE) && !range_bad;
        cmd.search = accept && (op == ble_pkg::OP_SEARCH);
        cmd.value  = value;
        cmd.pos    = pos;
        cmd.count  = count_reg;
    end

    for (genvar i = 0; i < ble_pkg::CAPACITY; i++)
    begin : g_cell
        logic [ble_pkg::VAL_W-1:0] left_data;
        logic [ble_pkg::VAL_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = value;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == ble_pkg::CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        ble_cell u_cell (
            .clk        (clk),
            .idx        (ble_pkg::idx_t'(i)),
            .cmd        (cmd),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    ble_or_tree u_tree (
        .clk   (clk),
        .match (cell_match),
        .any   (any_match)
    );

    always_comb
    begin
        count_next  = count_reg;
        state_next  = state_reg;
        wait_next   = wait_reg;
        status_next = status_reg;
        length_next = length_reg;
        found_next  = found_reg;
        if (cmd.insert || cmd.append)
        begin
            count_next = count_reg + ble_pkg::cnt_t'(1);
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - ble_pkg::cnt_t'(1);
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_BUSY;
                    wait_next   = ble_pkg::WAIT_W'(ble_pkg::TREE_LEVELS);
                    length_next = ble_pkg::len_t'(count_next);
                    status_next = ble_pkg::STATUS_OK;
                    if (full && (op inside {ble_pkg::OP_INSERT, ble_pkg::OP_APPEND}))
                    begin
                        status_next = ble_pkg::STATUS_FULL;
                    end
                    else if (range_bad && (op == ble_pkg::OP_REMOVE))
                    begin
                        status_next = ble_pkg::STATUS_RANGE;
                    end
                end
            end
            S_BUSY:
            begin
                if (wait_reg == '0)
                begin
                    found_next = any_match;
                    state_next = S_DONE;
                end
                else
                begin
                    wait_next = wait_reg - (ble_pkg::WAIT_W)'(1);
                end
            end
            S_DONE:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wait_reg  <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        length_reg <= length_next;
        found_reg  <= found_next;
    end

    assign m_tvalid = (state_reg == S_DONE);
    assign m_tdata  = {6'd0, length_reg, found_reg, status_reg};

    `BLE_ASSERT_NEVER(a_count_bound, count_reg > ble_pkg::cnt_t'(ble_pkg::CAPACITY))
    `BLE_ASSERT_IMPLY(a_full_len, m_tvalid && (status_reg == ble_pkg::STATUS_FULL),
                      length_reg == ble_pkg::len_t'(ble_pkg::CAPACITY))
    `BLE_ASSERT_IMPLY(a_found_ok, m_tvalid && found_reg, status_reg == ble_pkg::STATUS_OK)
    `BLE_ASSERT_NEXT(a_count_hold, !accept, count_reg == $past(count_reg))

endmodule

@@ rtl/ble_cell.sv @@
module ble_cell (
    input  logic                       clk,
    input  ble_pkg::idx_t              idx,
    input  ble_pkg::cmd_t              cmd,
    input  logic [ble_pkg::VAL_W-1:0]  left_data,
    input  logic [ble_pkg::VAL_W-1:0]  right_data,
    output logic [ble_pkg::VAL_W-1:0]  data,
    output logic                       match
);

    logic [ble_pkg::VAL_W-1:0] data_reg;
    logic [ble_pkg::VAL_W-1:0] data_next;
    logic                      match_reg;
    logic                      match_next;
    ble_pkg::cmp_t             idx_w;

    assign idx_w = ble_pkg::cmp_t'(idx);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.insert)
        begin
            data_next = (idx == '0) ? cmd.value : left_data;
        end
        else if (cmd.append && (idx_w == ble_pkg::cmp_t'(cmd.count)))
        begin
            data_next = cmd.value;
        end
        else if (cmd.remove && (idx_w >= ble_pkg::cmp_t'(cmd.pos)))
        begin
            data_next = right_data;
        end
    end

    assign match_next = cmd.search && (data_reg == cmd.value)
                        && (idx_w < ble_pkg::cmp_t'(cmd.count));

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

@@ rtl/ble_or_tree.sv @@
module ble_or_tree (
    input  logic                          clk,
    input  logic [ble_pkg::CAPACITY-1:0]  match,
    output logic                          any
);

    wire [ble_pkg::LANE_W-1:0] lvl [ble_pkg::TREE_LEVELS+1];

    assign lvl[0] = ble_pkg::LANE_W'(match);

    for (genvar l = 1; l <= ble_pkg::TREE_LEVELS; l++)
    begin : g_level
        for (genvar j = 0; j < ble_pkg::LANE_W; j++)
        begin : g_node
            if (j < ble_pkg::tree_width(l))
            begin : g_or
                logic node_reg;
                always_ff @(posedge clk)
                begin
                    node_reg <= |lvl[l-1][8*j +: 8];
                end
                assign lvl[l][j] = node_reg;
            end
            else
            begin : g_zero
                assign lvl[l][j] = 1'b0;
            end
        end
    end

    assign any = lvl[ble_pkg::TREE_LEVELS][0];

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import ble_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = TREE_LEVELS + 12;
    localparam int HOLDOFF_CYCLES = 400;

    typedef struct packed {
        len_t              length;
        logic              found;
        logic [STAT_W-1:0] status;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic [VAL_W-1:0] list_model[$];
    list_result_t     predicted_results[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int sink_hold = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int full_rejects = 0;
    int range_rejects = 0;
    int search_hits = 0;
    int peak_length = 0;
    int input_stalls = 0;

    bounded_list_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic list_result_t apply_list_cmd(input logic [OP_W-1:0] op,
                                                    input logic [VAL_W-1:0] val,
                                                    input logic [POS_W-1:0] pos);
        list_result_t res;
        res = '0;
        res.status = STATUS_OK;
        case (op)
            OP_INSERT:
            begin
                if (list_model.size() >= CAPACITY)
                    res.status = STATUS_FULL;
                else
                    list_model.push_front(val);
            end
            OP_APPEND:
            begin
                if (list_model.size() >= CAPACITY)
                    res.status = STATUS_FULL;
                else
                    list_model.push_back(val);
            end
            OP_SEARCH:
            begin
                foreach (list_model[i])
                begin
                    if (list_model[i] == val)
                        res.found = 1'b1;
                end
            end
            default:
            begin
                if (int'(pos) >= list_model.size())
                    res.status = STATUS_RANGE;
                else
                    list_model.delete(int'(pos));
            end
        endcase
        res.length = len_t'(list_model.size());
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH result %0d: %s expected %0d got %0d",
                 results_checked, what, want, got);
        mismatches++;
    endtask

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                            input logic [POS_W-1:0] pos);
        list_result_t res;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, pos, val};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        res = apply_list_cmd(op, val, pos);
        predicted_results.push_back(res);
        items_sent++;
        if (res.status == STATUS_FULL)
            full_rejects++;
        if (res.status == STATUS_RANGE)
            range_rejects++;
        if (res.found)
            search_hits++;
        if (list_model.size() > peak_length)
            peak_length = list_model.size();
    endtask

    always @(posedge clk)
    begin : result_monitor
        list_result_t got;
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[9:0];
            if (predicted_results.size() == 0)
            begin
                report_mismatch("unexpected result, raw", 0, int'(got));
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", want.status, got.status);
                if (got.found !== want.found)
                    report_mismatch("found", want.found, got.found);
                if (got.length !== want.length)
                    report_mismatch("length", want.length, got.length);
            end
            results_checked++;
        end
        if (sink_hold > 0)
        begin
            m_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && s_tvalid && !s_tready)
            input_stalls++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_directed_edges();
        send_cmd(OP_SEARCH, 8'h00, 6'd0);
        send_cmd(OP_REMOVE, 8'h00, 6'd0);
        send_cmd(OP_REMOVE, 8'hFF, 6'd63);
        send_cmd(OP_INSERT, 8'h00, 6'd63);
        send_cmd(OP_APPEND, 8'hFF, 6'd0);
        send_cmd(OP_INSERT, 8'h80, 6'd21);
        send_cmd(OP_APPEND, 8'h01, 6'd42);
        send_cmd(OP_SEARCH, 8'hFF, 6'd0);
        send_cmd(OP_SEARCH, 8'h00, 6'd0);
        send_cmd(OP_SEARCH, 8'h7F, 6'd63);
        send_cmd(OP_REMOVE, 8'h00, 6'd4);
        send_cmd(OP_REMOVE, 8'h00, 6'd3);
        send_cmd(OP_REMOVE, 8'h00, 6'd0);
        send_cmd(OP_SEARCH, 8'h01, 6'd0);
        send_cmd(OP_APPEND, 8'hAA, 6'd0);
        send_cmd(OP_REMOVE, 8'h55, 6'd1);
        send_cmd(OP_SEARCH, 8'hAA, 6'd0);
        send_cmd(OP_REMOVE, 8'h00, 6'd1);
        send_cmd(OP_REMOVE, 8'h00, 6'd0);
        send_cmd(OP_SEARCH, 8'hFF, 6'd0);
        send_cmd(OP_APPEND, 8'h55, 6'd0);
        send_cmd(OP_INSERT, 8'hAA, 6'd0);
        send_cmd(OP_REMOVE, 8'h00, 6'd2);
        send_cmd(OP_REMOVE, 8'h00, 6'd1);
        send_cmd(OP_REMOVE, 8'h00, 6'd0);
    endtask

    task automatic test_full_list();
        for (int i = 0; i < CAPACITY; i++)
            send_cmd(OP_APPEND, VAL_W'($urandom_range(255)), POS_W'($urandom_range(63)));
        send_cmd(OP_INSERT, 8'h3C, 6'd0);
        send_cmd(OP_APPEND, 8'hC3, 6'd63);
        send_cmd(OP_SEARCH, list_model[CAPACITY-1], 6'd0);
        send_cmd(OP_REMOVE, 8'h00, POS_W'(CAPACITY - 1));
        send_cmd(OP_REMOVE, 8'h00, POS_W'(CAPACITY - 1));
        send_cmd(OP_INSERT, 8'h5A, 6'd0);
        send_cmd(OP_SEARCH, 8'h5A, 6'd0);
        while (list_model.size() > 0)
            send_cmd(OP_REMOVE, VAL_W'($urandom_range(255)),
                     POS_W'($urandom_range(list_model.size() - 1)));
    endtask

    // climb toward full, linger, then drain toward empty, and repeat
    task automatic test_random_walk(input int n_items);
        bit               growing;
        int               r;
        int               len;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        growing = 1'b1;
        for (int n = 0; n < n_items; n++)
        begin
            len = list_model.size();
            if (growing && len == CAPACITY && $urandom_range(3) == 0)
                growing = 1'b0;
            else if (!growing && len == 0 && $urandom_range(3) == 0)
                growing = 1'b1;
            r = $urandom_range(99);
            val = VAL_W'($urandom_range(255));
            pos = POS_W'($urandom_range(63));
            if (r < 10)
                op = OP_SEARCH;
            else if (r < 20)
                op = growing ? OP_REMOVE : ((r < 15) ? OP_INSERT : OP_APPEND);
            else
                op = growing ? ((r < 60) ? OP_INSERT : OP_APPEND) : OP_REMOVE;
            if (op == OP_SEARCH && len > 0 && $urandom_range(1) == 1)
                val = list_model[$urandom_range(len - 1)];
            if (op == OP_REMOVE && len > 0 && $urandom_range(99) < 85)
                pos = POS_W'($urandom_range(len - 1));
            send_cmd(op, val, pos);
        end
    endtask

    // hold the sink off while commands keep coming, so the input backs up
    task automatic test_sink_holdoff();
        int saved_tx;
        saved_tx = tx_idle_pct;
        tx_idle_pct = 0;
        sink_hold = HOLDOFF_CYCLES;
        for (int i = 0; i < 12; i++)
            send_cmd(OP_APPEND + OP_W'(i % 3), VAL_W'($urandom_range(255)),
                     POS_W'($urandom_range(3)));
        tx_idle_pct = saved_tx;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 31;
        rx_idle_pct = 51;
        test_directed_edges();
        test_full_list();
        test_random_walk(290);

        tx_idle_pct = 51;
        rx_idle_pct = 31;
        test_sink_holdoff();
        test_random_walk(290);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_walk(290);

        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("commands sent %0d, results checked %0d, peak length %0d",
                 items_sent, results_checked, peak_length);
        $display("full rejects %0d, range rejects %0d, search hits %0d, input stalls %0d",
                 full_rejects, range_rejects, search_hits, input_stalls);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ bounded_list_engine.f @@
+incdir+rtl
rtl/ble_pkg.sv
rtl/ble_cell.sv
rtl/ble_or_tree.sv
rtl/bounded_list_engine.sv
bench/tb.sv
